[hw/rtl/pal16_pkg.sv]
// shared types, constants and helpers for the palette blend sampler
package pal16_pkg;

    localparam int CH_W   = 8;
    localparam int SLOT_W = 4;
    localparam int SEL_W  = 3;
    localparam int NCH    = 3;

    // mode codes of an input item
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [CH_W-1:0] BRIGHT_FULL = 8'hFF;

    // channel 2 red, 1 green, 0 blue
    typedef logic [NCH-1:0][CH_W-1:0] t_rgb;

    typedef struct packed {
        logic              pal_ok;
        logic [SLOT_W-1:0] frac;
        logic [CH_W-1:0]   bright;
    } t_ctrl;

    // upper byte of an 8 by 9 bit product
    function automatic logic [CH_W-1:0] mul_hi(input logic [CH_W-1:0] v,
                                               input logic [CH_W:0] s);
        logic [2*CH_W:0] p;
        p = {{CH_W{1'b0}}, v} * {{CH_W{1'b0}}, s};
        return p[2*CH_W-1:CH_W];
    endfunction

endpackage

[hw/rtl/pal16_if.sv]
// item channels of the palette blend sampler
interface pal16_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [pal16_pkg::SEL_W-1:0]    palette_select;
    logic [pal16_pkg::SLOT_W-1:0]   entry_slot;
    logic [pal16_pkg::CH_W-1:0]     entry_red;
    logic [pal16_pkg::CH_W-1:0]     entry_green;
    logic [pal16_pkg::CH_W-1:0]     entry_blue;
    logic [pal16_pkg::CH_W-1:0]     color_index;
    logic [pal16_pkg::CH_W-1:0]     brightness;

    modport source (
        output valid, mode, palette_select, entry_slot, entry_red, entry_green,
               entry_blue, color_index, brightness,
        input  ready
    );
    modport sink (
        input  valid, mode, palette_select, entry_slot, entry_red, entry_green,
               entry_blue, color_index, brightness,
        output ready
    );
endinterface

interface pal16_out_if;
    logic                       valid;
    logic                       ready;
    logic [pal16_pkg::CH_W-1:0] red;
    logic [pal16_pkg::CH_W-1:0] green;
    logic [pal16_pkg::CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[hw/rtl/pal16_ram.sv]
// generic ram: one write port, two registered read ports
module pal16_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

[hw/rtl/pal16_blend.sv]
// blend stage: weighted mix of a slot color with its neighbor
module pal16_blend (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  pal16_pkg::t_rgb               i_a,
    input  pal16_pkg::t_rgb               i_b,
    input  logic [pal16_pkg::SLOT_W-1:0]  i_frac,
    output pal16_pkg::t_rgb               o_rgb
);
    import pal16_pkg::*;

    logic [CH_W-1:0] w;
    logic [CH_W:0]   wt_a;
    logic [CH_W:0]   wt_b;
    t_rgb            n_rgb;
    t_rgb            r_rgb;

    always_comb begin
        w    = {i_frac, {(CH_W-SLOT_W){1'b0}}};
        // scale8 weights already carry the +1
        wt_a = 9'd256 - {1'b0, w};
        wt_b = {1'b0, w} + 9'd1;
        for (int c = 0; c < NCH; c++) begin
            // no fraction: the slot color stands alone, the neighbor is not used
            if (i_frac == '0) begin
                n_rgb[c] = i_a[c];
            end else begin
                n_rgb[c] = mul_hi(i_a[c], wt_a) + mul_hi(i_b[c], wt_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;
endmodule

[hw/rtl/pal16_dim.sv]
// brightness stage: scales each channel, output register of the block
module pal16_dim (
    input  logic              i_clk,
    input  logic              i_en,
    input  pal16_pkg::t_rgb   i_rgb,
    input  pal16_pkg::t_ctrl  i_ctrl,
    output pal16_pkg::t_rgb   o_rgb
);
    import pal16_pkg::*;

    logic [CH_W:0] sc;
    t_rgb          n_rgb;
    t_rgb          r_rgb;

    always_comb begin
        sc = {1'b0, i_ctrl.bright} + 9'd2;
        for (int c = 0; c < NCH; c++) begin
            if (!i_ctrl.pal_ok) begin
                n_rgb[c] = '0;
            end else if (i_ctrl.bright == BRIGHT_FULL) begin
                n_rgb[c] = i_rgb[c];
            end else if (i_ctrl.bright == '0 || i_rgb[c] == '0) begin
                n_rgb[c] = '0;
            end else begin
                n_rgb[c] = mul_hi(i_rgb[c], sc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;
endmodule

[hw/rtl/palette16_blend_sampler.sv]
// top level of the palette blend sampler
//
// i_in carries load items (mode 0), which write one palette entry and give
// no result, and sample items (mode 1), which give one color on o_out.
// An item is taken when valid and ready are both high.
// A sample passes the ram read, blend and brightness registers on its
// way to o_out.
// Throughput: one item per cycle while the stages are not stalled, loads
// and samples mixed freely; a sample right after a load of the same entry
// sees the new color. The rate is set by the palette ram, which gives both
// blend neighbors at once through two read ports.
// Sampling a palette at or above NUM_PALETTES gives black; a load there is
// dropped. Reading an entry never loaded gives an undefined color.
// Reset clears the pipeline valid bits only; palette contents are kept.
// When o_out.ready is low the stages hold and fill, and i_in.ready drops
// once all three stages are full; nothing is lost or repeated.
module palette16_blend_sampler #(
    parameter int NUM_PALETTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pal16_in_if.sink    i_in,
    pal16_out_if.source o_out
);
    import pal16_pkg::*;

    localparam int DEPTH = NUM_PALETTES * 16;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [8:0] NPAL = 9'(NUM_PALETTES);

    logic            accept;
    logic            is_sample;
    logic            pal_ok;
    logic            adv1;
    logic            adv2;
    logic            adv3;
    logic [AW+6:0]   waddr_full;
    logic [AW+6:0]   raddr_a_full;
    logic [AW+6:0]   raddr_b_full;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] slot_nxt;
    t_rgb            wdata;
    t_rgb            rd_a;
    t_rgb            rd_b;
    t_rgb            blend_rgb;
    t_rgb            dim_rgb;
    t_ctrl           n_c1;

    logic            r_v1;
    logic            r_v2;
    logic            r_v3;
    t_ctrl           r_c1;
    t_ctrl           r_c2;

    // stall chain: a stage loads when it is empty or its successor moves
    assign adv3 = !r_v3 || o_out.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_in.ready = adv1;
    assign accept     = i_in.valid && adv1;
    assign is_sample  = (i_in.mode == MODE_SAMPLE);
    assign pal_ok     = {6'b0, i_in.palette_select} < NPAL;

    assign slot     = i_in.color_index[CH_W-1:SLOT_W];
    assign slot_nxt = slot + 4'd1;

    assign waddr_full   = {{AW{1'b0}}, i_in.palette_select, i_in.entry_slot};
    assign raddr_a_full = {{AW{1'b0}}, i_in.palette_select, slot};
    assign raddr_b_full = {{AW{1'b0}}, i_in.palette_select, slot_nxt};
    assign wdata        = {i_in.entry_red, i_in.entry_green, i_in.entry_blue};

    assign n_c1.pal_ok = pal_ok;
    assign n_c1.frac   = i_in.color_index[SLOT_W-1:0];
    assign n_c1.bright = i_in.brightness;

    pal16_ram #(
        .WIDTH (NCH * CH_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (accept && !is_sample && pal_ok),
        .i_waddr   (waddr_full[AW-1:0]),
        .i_wdata   (wdata),
        .i_re      (accept && is_sample),
        .i_raddr_a (raddr_a_full[AW-1:0]),
        .i_raddr_b (raddr_b_full[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    pal16_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (adv2 && r_v1),
        .i_a    (rd_a),
        .i_b    (rd_b),
        .i_frac (r_c1.frac),
        .o_rgb  (blend_rgb)
    );

    pal16_dim u_dim (
        .i_clk  (i_clk),
        .i_en   (adv3 && r_v2),
        .i_rgb  (blend_rgb),
        .i_ctrl (r_c2),
        .o_rgb  (dim_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            // load items leave no trace in the pipeline
            if (adv1) begin
                r_v1 <= accept && is_sample;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            r_c1 <= n_c1;
        end
        if (adv2 && r_v1) begin
            r_c2 <= r_c1;
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.red   = dim_rgb[2];
    assign o_out.green = dim_rgb[1];
    assign o_out.blue  = dim_rgb[0];
endmodule

[tb/sv/tb.sv]
// self-checking testbench for the palette blend sampler: loads, blended samples, brightness
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal16_pkg::*;

    localparam int NUM_PAL = 8;
    localparam int NSLOT   = 16;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    typedef struct {
        logic              mode;
        logic [SEL_W-1:0]  sel;
        logic [SLOT_W-1:0] slot;
        t_color            entry;
        logic [CH_W-1:0]   cidx;
        logic [CH_W-1:0]   bright;
        bit                drain_first;
    } t_pal_item;

    logic i_clk;
    logic i_rst_n;

    pal16_in_if  in_ch ();
    pal16_out_if out_ch ();

    palette16_blend_sampler #(.NUM_PALETTES(NUM_PAL)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_pal_item pending_items[$];
    t_color    expected_colors[$];
    t_color    pal_mirror[NUM_PAL*NSLOT];
    bit        gen_loaded[NUM_PAL*NSLOT];

    logic        in_fire;
    int          n_taken;
    int          n_fail;
    int          burst_left;
    int          gap_left;
    int          stall_left;
    bit          long_stall_done;
    logic [31:0] rx_cycle;

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [CH_W-1:0] blend_chan(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b,
                                                   input logic [SLOT_W-1:0] f);
        int w;
        w = int'(f) << 4;
        return CH_W'(((int'(a) * (256 - w)) >> 8) + ((int'(b) * (w + 1)) >> 8));
    endfunction

    function automatic logic [CH_W-1:0] dim_chan(input logic [CH_W-1:0] v,
                                                 input logic [CH_W-1:0] br);
        if (br == 8'd255)
            return v;
        if (br == 8'd0 || v == 8'd0)
            return '0;
        return CH_W'((int'(v) * (int'(br) + 2)) >> 8);
    endfunction

    function automatic t_color sample_color(input logic [SEL_W-1:0] sel,
                                            input logic [CH_W-1:0] cidx,
                                            input logic [CH_W-1:0] br);
        t_color            a;
        t_color            b;
        t_color            res;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] f;
        if (int'(sel) >= NUM_PAL)
            return '0;
        nxt = cidx[7:4] + 4'd1;
        a   = pal_mirror[int'(sel)*NSLOT + int'(cidx[7:4])];
        b   = pal_mirror[int'(sel)*NSLOT + int'(nxt)];
        f   = cidx[3:0];
        if (f != 4'd0) begin
            a.red   = blend_chan(a.red, b.red, f);
            a.green = blend_chan(a.green, b.green, f);
            a.blue  = blend_chan(a.blue, b.blue, f);
        end
        res.red   = dim_chan(a.red, br);
        res.green = dim_chan(a.green, br);
        res.blue  = dim_chan(a.blue, br);
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] rand_bright();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // unused fields of either kind carry random noise
    task automatic add_load(input int sel, input int slot, input t_color c);
        t_pal_item it;
        it.mode        = MODE_LOAD;
        it.sel         = SEL_W'(sel);
        it.slot        = SLOT_W'(slot);
        it.entry       = c;
        it.cidx        = CH_W'($urandom_range(0, 255));
        it.bright      = CH_W'($urandom_range(0, 255));
        it.drain_first = 1'b0;
        if (sel < NUM_PAL)
            gen_loaded[sel*NSLOT + slot] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic add_sample(input int sel, input int cidx, input int br, input bit drain);
        t_pal_item it;
        it.mode        = MODE_SAMPLE;
        it.sel         = SEL_W'(sel);
        it.slot        = SLOT_W'($urandom_range(0, 15));
        it.entry       = {CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                          CH_W'($urandom_range(0, 255))};
        it.cidx        = CH_W'(cidx);
        it.bright      = CH_W'(br);
        it.drain_first = drain;
        pending_items.push_back(it);
    endtask

    task automatic add_random(input bit drain);
        int sel;
        int slot;
        int frac;
        int tries;
        bit found;
        sel   = int'($urandom_range(0, NUM_PAL-1));
        found = 1'b0;
        tries = 0;
        slot  = 0;
        while (!found && tries < 24) begin
            slot  = int'($urandom_range(0, 15));
            found = gen_loaded[sel*NSLOT + slot];
            tries++;
        end
        if ($urandom_range(0, 9) < 3 || !found) begin
            add_load(sel, int'($urandom_range(0, 15)),
                     {rand_chan(), rand_chan(), rand_chan()});
        end else begin
            frac = int'($urandom_range(0, 15));
            // a blend reads the next slot too, which must hold a loaded color
            if (frac != 0 && !gen_loaded[sel*NSLOT + ((slot + 1) % NSLOT)])
                frac = 0;
            add_sample(sel, (slot << 4) | frac, int'(rand_bright()), drain);
        end
        // the pause applies whichever kind of item was made
        pending_items[pending_items.size()-1].drain_first = drain;
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.mode           = MODE_LOAD;
        in_ch.palette_select = '0;
        in_ch.entry_slot     = '0;
        in_ch.entry_red      = '0;
        in_ch.entry_green    = '0;
        in_ch.entry_blue     = '0;
        in_ch.color_index    = '0;
        in_ch.brightness     = '0;
        out_ch.ready         = 1'b0;
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_fire         = 1'b0;
        n_taken         = 0;
        n_fail          = 0;
        burst_left      = 30;
        gap_left        = 0;
        stall_left      = 0;
        long_stall_done = 1'b0;
        rx_cycle        = '0;
        foreach (pal_mirror[k]) pal_mirror[k] = '0;
        foreach (gen_loaded[k]) gen_loaded[k] = 1'b0;

        // directed: extremes of slot, palette, color and brightness
        add_load(7, 15, {8'hFF, 8'h00, 8'h80});
        add_load(7, 0, {8'h00, 8'hFF, 8'h01});
        add_load(0, 0, {8'hFF, 8'hFF, 8'hFF});
        add_sample(0, 'h00, 128, 1'b0);
        add_sample(7, 'hF0, 255, 1'b0);
        add_sample(7, 'hFF, 255, 1'b0);
        add_sample(7, 'hF8, 0, 1'b0);
        add_sample(7, 'hF7, 1, 1'b0);
        add_sample(7, 'h00, 254, 1'b0);
        add_sample(7, 'hF1, 77, 1'b0);
        add_load(7, 1, {8'h01, 8'h02, 8'h03});
        add_sample(7, 'h10, 200, 1'b0);
        add_sample(7, 'h08, 255, 1'b0);
        // overwrite, then read the same entry right away
        add_load(7, 15, {8'h0C, 8'h22, 8'h38});
        add_sample(7, 'hF0, 255, 1'b0);
        add_sample(7, 'hFF, 254, 1'b0);
        add_load(0, 1, {8'h00, 8'h00, 8'h00});
        add_sample(0, 'h0F, 255, 1'b0);
        add_sample(0, 'h10, 2, 1'b0);

        for (int n = 0; n < 650; n++)
            add_random(n == 250 || n == 480);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || in_ch.valid)
            @(negedge i_clk);
        while (expected_colors.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (n_fail == 0)
            $display("[palette16_blend_sampler] OK");
        else
            $display("[palette16_blend_sampler] ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[palette16_blend_sampler] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin : drv
        t_pal_item it;
        logic      v;
        v = 1'b0;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (in_ch.valid && !in_fire) begin
            v = 1'b1;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && expected_colors.size() != 0)) begin
            it = pending_items.pop_front();
            in_ch.mode           <= it.mode;
            in_ch.palette_select <= it.sel;
            in_ch.entry_slot     <= it.slot;
            in_ch.entry_red      <= it.entry.red;
            in_ch.entry_green    <= it.entry.green;
            in_ch.entry_blue     <= it.entry.blue;
            in_ch.color_index    <= it.cidx;
            in_ch.brightness     <= it.bright;
            v = 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
                burst_left = int'($urandom_range(1, 40));
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            end
        end
        in_ch.valid <= v;
    end

    // ---------------------------------------------------------------- receiver

    always @(negedge i_clk) begin : rx
        logic rdy;
        rx_cycle = rx_cycle + 32'd1;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            rdy = 1'b0;
            stall_left = stall_left - 1;
        end else if (!long_stall_done && n_taken >= 200) begin
            // long hold-off while the sender keeps offering, to back the pipe up
            long_stall_done = 1'b1;
            stall_left = 120;
            rdy = 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: rdy = 1'b1;
                2'd1: rdy = 1'($urandom_range(0, 1));
                2'd2: rdy = (rx_cycle[1:0] != 2'd0);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        out_ch.ready <= rdy;
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : mon
        t_color want;
        t_color got;
        in_fire <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n_taken = n_taken + 1;
            if (in_ch.mode == MODE_LOAD) begin
                if (int'(in_ch.palette_select) < NUM_PAL)
                    pal_mirror[int'(in_ch.palette_select)*NSLOT + int'(in_ch.entry_slot)] =
                        {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
            end else begin
                expected_colors.push_back(sample_color(in_ch.palette_select,
                                                       in_ch.color_index, in_ch.brightness));
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.red, out_ch.green, out_ch.blue};
            if (expected_colors.size() == 0) begin
                if (n_fail < 10)
                    $display("unexpected color r=%0d g=%0d b=%0d at %0t",
                             got.red, got.green, got.blue, $realtime);
                n_fail = n_fail + 1;
            end else begin
                want = expected_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    if (n_fail < 10)
                        $display({"color mismatch at %0t: exp r=%0d g=%0d b=%0d",
                                  " got r=%0d g=%0d b=%0d"},
                                 $realtime, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    n_fail = n_fail + 1;
                end
            end
        end
    end

endmodule

[filelist.f]
hw/rtl/pal16_pkg.sv
hw/rtl/pal16_if.sv
hw/rtl/pal16_ram.sv
hw/rtl/pal16_blend.sv
hw/rtl/pal16_dim.sv
hw/rtl/palette16_blend_sampler.sv
tb/sv/tb.sv
